// ===== sv/pmrd_pkg.sv =====
package pmrd_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam int          FRAME_LEN  = 25;
   localparam int          CRC_SPAN   = 23;
   localparam int          DATA_FIRST = 3;
   localparam int          DATA_LEN   = 20;
   localparam int          COUNT_W    = 6;
   localparam int          INDEX_W    = $clog2(DATA_LEN);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_BAD_CRC    = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] voltage_raw;
      logic [31:0] current_raw;
      logic [31:0] power_raw;
      logic [31:0] energy_raw;
      logic [15:0] frequency_raw;
      logic [15:0] power_factor_raw;
      logic [15:0] alarm_word;
   } result_type;

   // reflected crc-16, one byte, bit by bit
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/pmrd_in_stage.sv =====
module pmrd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_last_byte,
   input  logic       advance,
   output logic       beat_valid,
   output logic [7:0] beat_byte,
   output logic       beat_last
);
   import pmrd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // hold the beat only while the core cannot take it
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_rx_byte;
         last_ff <= req_last_byte;
      end
   end

   assign beat_valid = valid_ff;
   assign beat_byte  = byte_ff;
   assign beat_last  = last_ff;

endmodule

// ===== sv/pmrd_frame_core.sv =====
module pmrd_frame_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic                 last_byte,
   output pmrd_pkg::result_type result
);
   import pmrd_pkg::*;

   logic [15:0]        crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         crc_low_ff, crc_low_in;
   logic [7:0]         payload_ff [DATA_LEN];
   logic               in_crc_span, in_data;
   logic [COUNT_W-1:0] data_off;
   logic [INDEX_W-1:0] data_index;

   assign in_crc_span = count_ff < COUNT_W'(CRC_SPAN);
   assign in_data     = in_crc_span && (count_ff >= COUNT_W'(DATA_FIRST));
   assign data_off    = count_ff - COUNT_W'(DATA_FIRST);
   assign data_index  = data_off[INDEX_W-1:0];

   always_comb begin
      crc_in     = crc_ff;
      count_in   = count_ff;
      crc_low_in = crc_low_ff;
      if (step) begin
         if (in_crc_span) begin
            crc_in = crc_next(crc_ff, rx_byte);
         end else if (count_ff == COUNT_W'(CRC_SPAN)) begin
            crc_low_in = rx_byte;
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         // frame ends: start over for the next one
         if (last_byte) begin
            crc_in   = CRC_INIT;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= CRC_INIT;
         count_ff   <= '0;
         crc_low_ff <= 8'h00;
      end else begin
         crc_ff     <= crc_in;
         count_ff   <= count_in;
         crc_low_ff <= crc_low_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DATA_LEN; i++) begin
         if (step && in_data && (data_index == INDEX_W'(i))) begin
            payload_ff[i] <= rx_byte;
         end
      end
   end

   // 32-bit values: low word first, each word big-endian
   always_comb begin
      result = '0;
      if (count_ff != COUNT_W'(FRAME_LEN - 1)) begin
         result.status = STATUS_BAD_LENGTH;
      end else if ({rx_byte, crc_low_ff} != crc_ff) begin
         result.status = STATUS_BAD_CRC;
      end else begin
         result.status           = STATUS_OK;
         result.voltage_raw      = {payload_ff[0], payload_ff[1]};
         result.current_raw      = {payload_ff[4], payload_ff[5],
                                    payload_ff[2], payload_ff[3]};
         result.power_raw        = {payload_ff[8], payload_ff[9],
                                    payload_ff[6], payload_ff[7]};
         result.energy_raw       = {payload_ff[12], payload_ff[13],
                                    payload_ff[10], payload_ff[11]};
         result.frequency_raw    = {payload_ff[14], payload_ff[15]};
         result.power_factor_raw = {payload_ff[16], payload_ff[17]};
         result.alarm_word       = {payload_ff[18], payload_ff[19]};
      end
   end

endmodule

// ===== sv/power_meter_response_decoder_unit.sv =====
// a result beat is registered: the result register loads when the core takes the final byte
// throughput: one byte per cycle unless stalled; the crc update is a single 8-step pass per byte
// a waiting result stalls the input only when the input register holds a final byte
// reset (synchronous, active high) clears the crc to all ones, the byte count to zero,
// the stored crc low byte and both valid flags; stored payload bytes are not cleared
module power_meter_response_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_voltage_raw,
   output logic [31:0] rsp_current_raw,
   output logic [31:0] rsp_power_raw,
   output logic [31:0] rsp_energy_raw,
   output logic [15:0] rsp_frequency_raw,
   output logic [15:0] rsp_power_factor_raw,
   output logic [15:0] rsp_alarm_word
);
   import pmrd_pkg::*;

   logic       beat_valid;
   logic [7:0] beat_byte;
   logic       beat_last;
   logic       advance;
   logic       step;
   logic       load;
   result_type core_result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // only a final byte needs room in the result register
   assign advance = !(beat_last && rsp_valid_ff && rsp_stall);
   assign step    = beat_valid && advance;
   assign load    = step && beat_last;

   pmrd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .beat_valid    (beat_valid),
      .beat_byte     (beat_byte),
      .beat_last     (beat_last)
   );

   pmrd_frame_core u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (beat_byte),
      .last_byte (beat_last),
      .result    (core_result)
   );

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= core_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = result_ff.status;
   assign rsp_voltage_raw      = result_ff.voltage_raw;
   assign rsp_current_raw      = result_ff.current_raw;
   assign rsp_power_raw        = result_ff.power_raw;
   assign rsp_energy_raw       = result_ff.energy_raw;
   assign rsp_frequency_raw    = result_ff.frequency_raw;
   assign rsp_power_factor_raw = result_ff.power_factor_raw;
   assign rsp_alarm_word       = result_ff.alarm_word;

endmodule

// ===== dv/power_meter_response_decoder_unit_test.sv =====
`timescale 1ns / 100ps

module power_meter_response_decoder_unit_test;
   import pmrd_pkg::*;

   localparam int BYTE_TARGET = 1650;

   typedef enum int {FRAME_GOOD, FRAME_CORRUPT, FRAME_ODD_LENGTH, FRAME_LONG} frame_kind_type;

   // reflected crc-16 over one byte, lsb first
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) begin
            c = {1'b0, c[15:1]} ^ 16'hA001;
         end else begin
            c = {1'b0, c[15:1]};
         end
      end
      return c;
   endfunction

   class frame_checker;
      logic [15:0]        crc_acc;
      logic [COUNT_W-1:0] seen;
      logic [7:0]         data_bytes[DATA_LEN];
      logic [7:0]         crc_lo;
      result_type         expected_replies[$];
      int                 mismatches;

      function new();
         crc_acc = CRC_INIT;
         seen = '0;
         crc_lo = 8'h00;
         mismatches = 0;
         foreach (data_bytes[i]) data_bytes[i] = 8'h00;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void note_byte(input logic [7:0] b, input logic last);
         int         pos;
         result_type r;
         pos = seen;
         if (pos < CRC_SPAN) begin
            crc_acc = crc16_step(crc_acc, b);
            if (pos >= DATA_FIRST) data_bytes[pos - DATA_FIRST] = b;
         end else if (pos == CRC_SPAN) begin
            crc_lo = b;
         end
         if (seen != COUNT_MAX) seen = seen + 1'b1;
         if (!last) return;
         r = '0;
         if (pos != FRAME_LEN - 1) begin
            r.status = STATUS_BAD_LENGTH;
         end else if ({b, crc_lo} != crc_acc) begin
            r.status = STATUS_BAD_CRC;
         end else begin
            // 32-bit values: low word first, each word big-endian
            r.status           = STATUS_OK;
            r.voltage_raw      = {data_bytes[0], data_bytes[1]};
            r.current_raw      = {data_bytes[4], data_bytes[5], data_bytes[2], data_bytes[3]};
            r.power_raw        = {data_bytes[8], data_bytes[9], data_bytes[6], data_bytes[7]};
            r.energy_raw       = {data_bytes[12], data_bytes[13], data_bytes[10], data_bytes[11]};
            r.frequency_raw    = {data_bytes[14], data_bytes[15]};
            r.power_factor_raw = {data_bytes[16], data_bytes[17]};
            r.alarm_word       = {data_bytes[18], data_bytes[19]};
         end
         expected_replies.push_back(r);
         crc_acc = CRC_INIT;
         seen = '0;
      endfunction

      function void match(input string field, input logic [31:0] want, input logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(input result_type got);
         result_type want;
         if (expected_replies.size() == 0) begin
            $error("reply beat with no frame pending");
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         match("status", want.status, got.status);
         match("voltage_raw", want.voltage_raw, got.voltage_raw);
         match("current_raw", want.current_raw, got.current_raw);
         match("power_raw", want.power_raw, got.power_raw);
         match("energy_raw", want.energy_raw, got.energy_raw);
         match("frequency_raw", want.frequency_raw, got.frequency_raw);
         match("power_factor_raw", want.power_factor_raw, got.power_factor_raw);
         match("alarm_word", want.alarm_word, got.alarm_word);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_voltage_raw;
   logic [31:0] rsp_current_raw;
   logic [31:0] rsp_power_raw;
   logic [31:0] rsp_energy_raw;
   logic [15:0] rsp_frequency_raw;
   logic [15:0] rsp_power_factor_raw;
   logic [15:0] rsp_alarm_word;

   frame_checker board = new();
   logic [7:0]   frame_q[$];
   bit           gaps_on = 1'b1;
   int           bytes_sent = 0;

   power_meter_response_decoder_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_voltage_raw(rsp_voltage_raw),
      .rsp_current_raw(rsp_current_raw),
      .rsp_power_raw(rsp_power_raw),
      .rsp_energy_raw(rsp_energy_raw),
      .rsp_frequency_raw(rsp_frequency_raw),
      .rsp_power_factor_raw(rsp_power_factor_raw),
      .rsp_alarm_word(rsp_alarm_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // reply side: check taken beats, then pick next cycle's stall
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status           = status_type'(rsp_status);
         got.voltage_raw      = rsp_voltage_raw;
         got.current_raw      = rsp_current_raw;
         got.power_raw        = rsp_power_raw;
         got.energy_raw       = rsp_energy_raw;
         got.frequency_raw    = rsp_frequency_raw;
         got.power_factor_raw = rsp_power_factor_raw;
         got.alarm_word       = rsp_alarm_word;
         board.check_reply(got);
      end
      rsp_stall <= gaps_on && ($urandom_range(99) < 25);
   end

   task send_byte(input logic [7:0] b, input logic last);
      while (gaps_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b, last);
      bytes_sent++;
   endtask

   task send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   task fill_frame(input int len);
      frame_q.delete();
      repeat (len) frame_q.push_back(8'($urandom));
   endtask

   // crc over the first 23 bytes goes into bytes 23 (low) and 24 (high)
   task seal_frame();
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) c = crc16_step(c, frame_q[i]);
      frame_q[CRC_SPAN]     = c[7:0];
      frame_q[CRC_SPAN + 1] = c[15:8];
   endtask

   task build_frame(input frame_kind_type kind);
      case (kind)
         FRAME_GOOD: begin
            fill_frame(FRAME_LEN);
            seal_frame();
         end
         FRAME_CORRUPT: begin
            fill_frame(FRAME_LEN);
            seal_frame();
            frame_q[$urandom_range(FRAME_LEN - 1)] ^= 8'($urandom_range(255, 1));
         end
         FRAME_ODD_LENGTH: begin
            fill_frame($urandom_range(1, 30));
            if (frame_q.size() >= FRAME_LEN) seal_frame();
         end
         default: begin
            fill_frame($urandom_range(40, 80));
         end
      endcase
   endtask

   task wait_for_replies();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int              pick;
      int              frames;
      frame_kind_type  kind;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all-ones measurement block with a correct crc
      fill_frame(FRAME_LEN);
      for (int i = DATA_FIRST; i < CRC_SPAN; i++) frame_q[i] = 8'hFF;
      seal_frame();
      send_frame();
      // all-zero block, crc high byte broken
      fill_frame(FRAME_LEN);
      for (int i = DATA_FIRST; i < CRC_SPAN; i++) frame_q[i] = 8'h00;
      seal_frame();
      frame_q[FRAME_LEN - 1] ^= 8'h80;
      send_frame();
      // one-byte frame
      send_byte(8'hFF, 1'b1);
      // long frame, count saturates
      fill_frame(70);
      send_frame();

      frames = 0;
      while (bytes_sent < BYTE_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 70) kind = FRAME_GOOD;
         else if (pick < 82) kind = FRAME_CORRUPT;
         else if (pick < 97) kind = FRAME_ODD_LENGTH;
         else kind = FRAME_LONG;
         // a calm stretch with no gaps on either side
         gaps_on = !(frames >= 30 && frames < 40);
         build_frame(kind);
         send_frame();
         if (frames == 20) wait_for_replies();
         frames++;
      end
      gaps_on = 1'b1;

      wait_for_replies();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pmrd_pkg.sv
sv/pmrd_in_stage.sv
sv/pmrd_frame_core.sv
sv/power_meter_response_decoder_unit.sv
dv/power_meter_response_decoder_unit_test.sv
